// ===== rtl/dqr_pkg.sv =====
// Shared types and constants for the bounded deque with remove by value.
// Used by dqr_cell, dqr_ctrl and deque_with_remove_by_value_core; no dependencies.
`default_nettype none

package dqr_pkg;

   localparam int DEPTH    = 16;
   localparam int DATA_W   = 32;
   localparam int CNT_W    = $clog2(DEPTH + 1);

   // Item field widths and packed stream widths.
   localparam int FUNC_W   = 3;
   localparam int WORD_W   = 32;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;
   localparam int REQ_W    = 40;
   localparam int RSP_W    = 40;

   typedef enum logic [FUNC_W-1:0] {
      FN_PUSH_HEAD = 3'd0,
      FN_PUSH_TAIL = 3'd1,
      FN_POP_HEAD  = 3'd2,
      FN_POP_TAIL  = 3'd3,
      FN_SEARCH    = 3'd4,
      FN_REMOVE    = 3'd5
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      STS_OK   = 2'd0,
      STS_MISS = 2'd1,
      STS_FULL = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      OP_NOP,
      OP_PUSH_HEAD,
      OP_PUSH_TAIL,
      OP_POP_HEAD,
      OP_POP_TAIL,
      OP_SCAN_START,
      OP_SCAN_STEP,
      OP_REMOVE
   } cell_op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DONE
   } state_type;

   // Command broadcast to every cell of the chain.
   typedef struct packed {
      cell_op_type       op;
      logic [DATA_W-1:0] key;
   } cell_cmd_type;

   // What one cell shows to its neighbors.
   typedef struct packed {
      logic              valid;
      logic              checked;
      logic [DATA_W-1:0] value;
   } cell_link_type;

endpackage

`default_nettype wire

// ===== rtl/dqr_cell.sv =====
// One position of the deque chain: a stored word, its valid flag and a scan mark.
// Depends on dqr_pkg for the command and neighbor link types.
`default_nettype none

module dqr_cell (
   input  logic                   clock,
   input  logic                   reset,
   input  dqr_pkg::cell_cmd_type  cmd,
   input  dqr_pkg::cell_link_type left,
   input  dqr_pkg::cell_link_type right,
   output dqr_pkg::cell_link_type self,
   output logic                   hit
);
   import dqr_pkg::*;

   logic              valid_ff, valid_in;
   logic              checked_ff, checked_in;
   logic [DATA_W-1:0] value_ff, value_in;
   logic              probe;

   // The scan token sits on the first cell not yet checked.
   assign probe = !checked_ff && left.checked;
   assign hit   = probe && valid_ff && (value_ff == cmd.key);

   assign self.valid   = valid_ff;
   assign self.checked = checked_ff;
   assign self.value   = value_ff;

   always_comb begin
      valid_in   = valid_ff;
      value_in   = value_ff;
      checked_in = checked_ff;
      case (cmd.op)
         OP_PUSH_HEAD: begin
            valid_in = left.valid;
            value_in = left.value;
         end
         OP_PUSH_TAIL: begin
            if (!valid_ff && left.valid) begin
               valid_in = 1'b1;
               value_in = cmd.key;
            end
         end
         OP_POP_HEAD: begin
            valid_in = right.valid;
            value_in = right.value;
         end
         OP_POP_TAIL: begin
            if (valid_ff && !right.valid) begin
               valid_in = 1'b0;
            end
         end
         OP_SCAN_START: begin
            checked_in = 1'b0;
         end
         OP_SCAN_STEP: begin
            checked_in = checked_ff | probe;
         end
         OP_REMOVE: begin
            // The matching cell and everything behind it close the gap.
            if (!checked_ff) begin
               valid_in = right.valid;
               value_in = right.value;
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         checked_ff <= 1'b0;
      end else begin
         valid_ff   <= valid_in;
         checked_ff <= checked_in;
      end
      value_ff <= value_in;
   end

endmodule

`default_nettype wire

// ===== rtl/dqr_ctrl.sv =====
// Sequencer of the deque: takes items, drives the cell chain, counts entries and
// holds the result register. Depends on dqr_pkg.
`default_nettype none

module dqr_ctrl (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_tvalid,
   output logic                        req_tready,
   input  logic [dqr_pkg::REQ_W-1:0]   req_tdata,
   output logic                        rsp_tvalid,
   input  logic                        rsp_tready,
   output logic [dqr_pkg::RSP_W-1:0]   rsp_tdata,
   input  logic                        hit_any,
   input  logic [dqr_pkg::DATA_W-1:0]  head_value,
   input  logic [dqr_pkg::DATA_W-1:0]  tail_value,
   output dqr_pkg::cell_cmd_type       cmd
);
   import dqr_pkg::*;

   state_type         state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   func_type          func_ff;
   logic [DATA_W-1:0] key_ff;
   status_type        res_status_ff, res_status_in;
   logic [DATA_W-1:0] res_data_ff, res_data_in;

   logic              rsp_valid_ff;
   status_type        rsp_status_ff;
   logic [DATA_W-1:0] rsp_data_ff;
   logic [CNT_W-1:0]  rsp_count_ff;
   logic              rsp_empty_ff;

   logic              accept;
   logic              rsp_free;
   logic              scan_end;
   func_type          req_func;
   logic [DATA_W-1:0] req_key;
   logic              is_full;
   logic              is_none;

   assign req_func = func_type'(req_tdata[FUNC_W-1:0]);
   assign req_key  = DATA_W'(req_tdata[FUNC_W +: WORD_W]);
   assign accept   = req_tvalid && req_tready;
   assign rsp_free = !rsp_valid_ff || rsp_tready;
   assign scan_end = (idx_ff == count_ff);
   assign is_full  = (count_ff == CNT_W'(DEPTH));
   assign is_none  = (count_ff == '0);

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               if (req_func == FN_SEARCH || req_func == FN_REMOVE) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_SCAN: begin
            if (scan_end || hit_any) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs and datapath control.
   always_comb begin
      req_tready    = (state_ff == ST_IDLE);
      cmd.op        = OP_NOP;
      cmd.key       = (state_ff == ST_IDLE) ? req_key : key_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      res_status_in = res_status_ff;
      res_data_in   = res_data_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               res_data_in   = '0;
               res_status_in = STS_MISS;
               case (req_func)
                  FN_PUSH_HEAD, FN_PUSH_TAIL: begin
                     if (is_full) begin
                        res_status_in = STS_FULL;
                     end else begin
                        cmd.op        = (req_func == FN_PUSH_HEAD) ? OP_PUSH_HEAD
                                                                   : OP_PUSH_TAIL;
                        count_in      = count_ff + CNT_W'(1);
                        res_status_in = STS_OK;
                     end
                  end
                  FN_POP_HEAD, FN_POP_TAIL: begin
                     if (!is_none) begin
                        cmd.op        = (req_func == FN_POP_HEAD) ? OP_POP_HEAD
                                                                  : OP_POP_TAIL;
                        res_data_in   = (req_func == FN_POP_HEAD) ? head_value
                                                                  : tail_value;
                        count_in      = count_ff - CNT_W'(1);
                        res_status_in = STS_OK;
                     end
                  end
                  FN_SEARCH, FN_REMOVE: begin
                     cmd.op = OP_SCAN_START;
                     idx_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (scan_end) begin
               res_status_in = STS_MISS;
            end else if (hit_any) begin
               res_status_in = STS_OK;
               if (func_ff == FN_REMOVE) begin
                  cmd.op   = OP_REMOVE;
                  count_in = count_ff - CNT_W'(1);
               end
            end else begin
               cmd.op = OP_SCAN_STEP;
               idx_in = idx_ff + CNT_W'(1);
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         idx_ff   <= idx_in;
         if (state_ff == ST_DONE && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      res_status_ff <= res_status_in;
      res_data_ff   <= res_data_in;
      if (accept) begin
         func_ff <= req_func;
         key_ff  <= req_key;
      end
      if (state_ff == ST_DONE && rsp_free) begin
         rsp_status_ff <= res_status_ff;
         rsp_data_ff   <= res_data_ff;
         rsp_count_ff  <= count_ff;
         rsp_empty_ff  <= is_none;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_empty_ff, COUNT_W'(rsp_count_ff), WORD_W'(rsp_data_ff),
                        rsp_status_ff};

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("entry count exceeds the chain depth");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (idx_ff <= count_ff))
      else $error("scan position ran past the last entry");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result presented without a finished item");

   a_full_push_drops: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_func == FN_PUSH_HEAD || req_func == FN_PUSH_TAIL) && is_full)
      |=> ($stable(count_ff) && state_ff == ST_DONE && res_status_ff == STS_FULL))
      else $error("push into a full chain changed the entry count");

endmodule

`default_nettype wire

// ===== rtl/deque_with_remove_by_value_core.sv =====
// Bounded deque with push and pop at both ends and search or remove by value.
//
// Input channel req_*: one item per handshake, func in req_tdata[2:0] and the
// data word in req_tdata[34:3]. Result channel rsp_*: exactly one result per
// item, in item order, carrying status, popped word, entry count and empty flag.
// The entries live in a row of 16 cells, head in cell 0; pushes and pops at the
// head shift the row one place, while at the tail they fill the first free cell
// or clear the last valid one. Search and remove pass a token from cell to cell,
// one comparison per cycle, stopping at the first match or after the last entry.
// An item is accepted only in the idle state, so the block takes no new item
// until the last one has left the done state. The result moves into the
// output register as the item leaves the done state.
// Reset empties the chain and drops any pending result; no clearing pass.
// When the receiver stalls, the result holds in the output register; the
// block still takes one more item, works it, and then waits until the
// register is free before taking another.
// Depends on dqr_pkg, dqr_cell and dqr_ctrl.
`default_nettype none

module deque_with_remove_by_value_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   // func [2:0], data_in [34:3], zero fill [39:35]
   input  logic [dqr_pkg::REQ_W-1:0] req_tdata,
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // status [1:0], data_out [33:2], entry_count [38:34], is_empty [39]
   output logic [dqr_pkg::RSP_W-1:0] rsp_tdata
);
   import dqr_pkg::*;

   cell_cmd_type      cmd;
   cell_link_type     lnk   [DEPTH+1];
   cell_link_type     right [DEPTH];
   logic [DEPTH-1:0]  hit_vec;
   logic [DEPTH-1:0]  tail_sel;
   logic              hit_any;
   logic [DATA_W-1:0] tail_value;

   // The head end feeds the key in and starts the scan token.
   assign lnk[0].valid   = 1'b1;
   assign lnk[0].checked = 1'b1;
   assign lnk[0].value   = cmd.key;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      if (i == DEPTH - 1) begin : g_last
         assign right[i].valid   = 1'b0;
         assign right[i].checked = 1'b0;
         assign right[i].value   = '0;
      end else begin : g_mid
         assign right[i] = lnk[i+2];
      end

      assign tail_sel[i] = lnk[i+1].valid && !right[i].valid;

      dqr_cell u_cell (
         .clock (clock),
         .reset (reset),
         .cmd   (cmd),
         .left  (lnk[i]),
         .right (right[i]),
         .self  (lnk[i+1]),
         .hit   (hit_vec[i])
      );
   end

   assign hit_any = |hit_vec;

   always_comb begin
      tail_value = '0;
      for (int i = 0; i < DEPTH; i++) begin
         tail_value = tail_value | (lnk[i+1].value & {DATA_W{tail_sel[i]}});
      end
   end

   dqr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .hit_any    (hit_any),
      .head_value (lnk[1].value),
      .tail_value (tail_value),
      .cmd        (cmd)
   );

endmodule

`default_nettype wire

// ===== verif/deque_with_remove_by_value_checker.sv =====
`timescale 1ns / 100ps
// Checker for the bounded deque: it watches both streams, keeps its own copy of the sequence,
// predicts each result and compares it field by field. Depends on dqr_pkg only.

module deque_checker
   import dqr_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   input  logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,
   input  logic             rsp_tvalid,
   input  logic             rsp_tready,
   input  logic [RSP_W-1:0] rsp_tdata,
   output int               error_count,
   output int               pending_count
);

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [WORD_W-1:0]   word;
      logic [COUNT_W-1:0]  count;
      logic                empty;
   } outcome_t;

   // Head of the sequence is element 0.
   logic [DATA_W-1:0] held_words[$];
   outcome_t          expected_outcomes[$];
   int                mismatches = 0;

   // Applies one operation to the held sequence and returns what the block should answer.
   function automatic outcome_t apply_operation(input logic [FUNC_W-1:0] fn,
                                                input logic [WORD_W-1:0] word);
      outcome_t result;
      int       hit;
      result.status = STS_MISS;
      result.word   = '0;
      hit           = -1;
      if (fn == FN_SEARCH || fn == FN_REMOVE) begin
         for (int i = 0; i < held_words.size(); i++) begin
            if (hit < 0 && held_words[i] == word[DATA_W-1:0]) hit = i;
         end
      end
      case (fn)
         FN_PUSH_HEAD, FN_PUSH_TAIL: begin
            if (held_words.size() >= DEPTH) begin
               result.status = STS_FULL;
            end else begin
               if (fn == FN_PUSH_HEAD) held_words.push_front(word[DATA_W-1:0]);
               else held_words.push_back(word[DATA_W-1:0]);
               result.status = STS_OK;
            end
         end
         FN_POP_HEAD, FN_POP_TAIL: begin
            if (held_words.size() != 0) begin
               if (fn == FN_POP_HEAD) result.word = held_words.pop_front();
               else result.word = held_words.pop_back();
               result.status = STS_OK;
            end
         end
         FN_SEARCH: begin
            if (hit >= 0) result.status = STS_OK;
         end
         FN_REMOVE: begin
            if (hit >= 0) begin
               held_words.delete(hit);
               result.status = STS_OK;
            end
         end
         default: ;
      endcase
      result.count = COUNT_W'(held_words.size());
      result.empty = (held_words.size() == 0);
      return result;
   endfunction

   always @(posedge clock) begin
      outcome_t oldest;
      outcome_t seen;
      if (reset) begin
         held_words.delete();
         expected_outcomes.delete();
      end else begin
         // Results are checked before new items are predicted, so a result never
         // matches against an item taken in the same cycle.
         if (rsp_tvalid && rsp_tready) begin
            seen = {rsp_tdata[1:0], rsp_tdata[33:2], rsp_tdata[38:34], rsp_tdata[39]};
            if (expected_outcomes.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("unexpected result %h with nothing outstanding", rsp_tdata);
            end else begin
               oldest = expected_outcomes.pop_front();
               if (seen.status !== oldest.status || seen.word !== oldest.word ||
                   seen.count !== oldest.count || seen.empty !== oldest.empty) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"mismatch at %0t: expected status %0d word %h count %0d",
                               " empty %0d, got status %0d word %h count %0d empty %0d"},
                              $realtime, oldest.status, oldest.word, oldest.count,
                              oldest.empty, seen.status, seen.word, seen.count, seen.empty);
               end
            end
         end
         if (req_tvalid && req_tready)
            expected_outcomes.push_back(apply_operation(req_tdata[2:0], req_tdata[34:3]));
      end
      error_count   <= mismatches;
      pending_count <= expected_outcomes.size();
   end

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps
// Testbench top for deque_with_remove_by_value_core: makes the stimulus and gives the verdict.
// Depends on dqr_pkg, the core RTL and deque_checker.

module tb;
   import dqr_pkg::*;

   localparam logic [FUNC_W-1:0] FN_UNUSED_6 = 3'd6;
   localparam logic [FUNC_W-1:0] FN_UNUSED_7 = 3'd7;

   localparam int MODE_FILL  = 0;
   localparam int MODE_DRAIN = 1;
   localparam int MODE_MIX   = 2;

   localparam int ITEMS_PER_PHASE = 583;

   logic             clock      = 1'b0;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata  = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   int               error_count;
   int               pending_count;

   int               gap_pct   = 8;
   int               stall_pct = 61;
   logic [WORD_W-1:0] word_pool[6];

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   deque_with_remove_by_value_core u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   deque_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tdata     (req_tdata),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .error_count   (error_count),
      .pending_count (pending_count)
   );

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= stall_pct);
   end

   // Offers one item after a random gap and returns once it has been taken.
   task automatic send_item(input logic [FUNC_W-1:0] fn, input logic [WORD_W-1:0] word);
      while ($urandom_range(0, 99) < gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {{(REQ_W - WORD_W - FUNC_W){1'b0}}, word, fn};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // Mostly words from a small pool, so that searches and removes hit and duplicates occur.
   function automatic logic [WORD_W-1:0] pick_word();
      if ($urandom_range(0, 99) < 65) return word_pool[$urandom_range(0, 5)];
      return $urandom();
   endfunction

   function automatic logic [FUNC_W-1:0] pick_func(input int mode);
      int roll;
      int push_share;
      int pop_share;
      roll = $urandom_range(0, 99);
      push_share = (mode == MODE_FILL) ? 55 : (mode == MODE_DRAIN) ? 12 : 30;
      pop_share  = (mode == MODE_FILL) ? 12 : (mode == MODE_DRAIN) ? 55 : 30;
      if (roll < 3) return $urandom_range(0, 1) ? FN_UNUSED_7 : FN_UNUSED_6;
      roll -= 3;
      if (roll < push_share) return $urandom_range(0, 1) ? FN_PUSH_TAIL : FN_PUSH_HEAD;
      if (roll < push_share + pop_share)
         return $urandom_range(0, 1) ? FN_POP_TAIL : FN_POP_HEAD;
      return $urandom_range(0, 1) ? FN_REMOVE : FN_SEARCH;
   endfunction

   initial begin
      int mode;
      int burst_left;
      word_pool[0] = '0;
      word_pool[1] = '1;
      for (int i = 2; i < 6; i++) word_pool[i] = $urandom();

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Empty sequence: pops, search and remove all miss; unused codes do nothing.
      send_item(FN_POP_HEAD, '1);
      send_item(FN_POP_TAIL, '0);
      send_item(FN_SEARCH, '0);
      send_item(FN_REMOVE, '1);
      send_item(FN_UNUSED_6, $urandom());
      send_item(FN_UNUSED_7, $urandom());
      send_item(FN_PUSH_HEAD, '0);
      send_item(FN_PUSH_TAIL, '1);
      send_item(FN_SEARCH, '1);
      // Fill to capacity with a repeated word, then overflow and remove the first copy.
      for (int i = 0; i < 16; i++) begin
         send_item(i[0] ? FN_PUSH_TAIL : FN_PUSH_HEAD,
                   (i % 5 == 0) ? 32'hA5A5_5A5A : $urandom());
      end
      send_item(FN_PUSH_HEAD, 32'h1234_5678);
      send_item(FN_REMOVE, 32'hA5A5_5A5A);

      for (int phase = 0; phase < 3; phase++) begin
         gap_pct   = (phase == 0) ? 8 : (phase == 1) ? 61 : 0;
         stall_pct = (phase == 0) ? 61 : (phase == 1) ? 8 : 0;
         burst_left = 0;
         mode = MODE_MIX;
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (burst_left == 0) begin
               mode = $urandom_range(MODE_FILL, MODE_MIX);
               burst_left = $urandom_range(20, 60);
            end
            burst_left--;
            send_item(pick_func(mode), pick_word());
         end
      end
      req_tvalid <= 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (error_count == 0 && pending_count == 0) begin
         $display("PASS deque_with_remove_by_value_core");
      end else begin
         $display("FAIL deque_with_remove_by_value_core");
      end
      $finish;
   end

   initial begin
      #4_800_000;
      $display("FAIL deque_with_remove_by_value_core");
      $finish;
   end

endmodule

// ===== files.f =====
rtl/dqr_pkg.sv
rtl/dqr_cell.sv
rtl/dqr_ctrl.sv
rtl/deque_with_remove_by_value_core.sv
verif/deque_with_remove_by_value_checker.sv
verif/tb.sv
